// ===== hw/rtl/cgbvd_pkg.sv =====
// Package for the colour-mode VRAM DMA and system register block.
// Holds operation codes, register addresses, the input word and result types.
// No dependencies.
`timescale 1ns / 1ps

package cgbvd_pkg;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_SPEED = 2'd3
	} op_t;

	localparam logic [7:0] ADDR_KEY1  = 8'h4D;
	localparam logic [7:0] ADDR_SRC_H = 8'h51;
	localparam logic [7:0] ADDR_SRC_L = 8'h52;
	localparam logic [7:0] ADDR_DST_H = 8'h53;
	localparam logic [7:0] ADDR_DST_L = 8'h54;
	localparam logic [7:0] ADDR_CTRL  = 8'h55;
	localparam logic [7:0] ADDR_SVBK  = 8'h70;

	localparam logic [7:0] READ_NONE  = 8'hFF;
	localparam logic [2:0] BANK_RESET = 3'd1;
	localparam logic [6:0] BLOCKS_DONE = 7'h7F;

	typedef struct packed {
		op_t        operation;
		logic [7:0] reg_address;
		logic [7:0] write_data;
		logic       in_hblank;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        copy_valid;
		logic [15:0] copy_source;
		logic [15:0] copy_dest;
		logic [7:0]  block_count;
		logic [10:0] stall_cycles;
		logic [2:0]  work_bank;
		logic        double_speed;
	} result_t;

endpackage

// ===== hw/rtl/cgbvd_in_stage.sv =====
// Input register stage of the VRAM DMA register block.
// Depends on cgbvd_pkg for the input word type.
`timescale 1ns / 1ps

module cgbvd_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  cgbvd_pkg::item_t item,
	input  logic            advance,
	output logic            valid_s1,
	output cgbvd_pkg::item_t item_s1
);

	logic vld_s1;

	assign in_stall = vld_s1 & ~advance;
	assign valid_s1 = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== hw/rtl/cgbvd_core.sv =====
// Register state and per-word logic: DMA registers, speed switch, bank select.
// Depends on cgbvd_pkg for codes, addresses and the word types.
`timescale 1ns / 1ps

module cgbvd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              color_mode,
	input  logic              fire,
	input  cgbvd_pkg::item_t  item,
	output cgbvd_pkg::result_t result
);

	logic [7:0]  src_hi_q, src_hi_d;
	logic [7:0]  src_lo_q, src_lo_d;
	logic [4:0]  dst_hi_q, dst_hi_d;
	logic [7:0]  dst_lo_q, dst_lo_d;
	logic [15:0] src_ptr_q, src_ptr_d;
	logic [15:0] dst_ptr_q, dst_ptr_d;
	logic [6:0]  blocks_q, blocks_d;
	logic        hblank_q, hblank_d;
	logic        active_q, active_d;
	logic        speed_q, speed_d;
	logic        armed_q, armed_d;
	logic [2:0]  bank_q, bank_d;

	logic [7:0]  cnt;
	logic [15:0] step;
	logic        gate;
	logic        issue;

	assign gate = ~color_mode;
	assign cnt  = hblank_q ? 8'd1 : ({1'b0, blocks_q} + 8'd1);
	assign step = {4'b0, cnt, 4'b0};
	assign issue = active_q & (~hblank_q | item.in_hblank);

	always_comb begin
		src_hi_d  = src_hi_q;
		src_lo_d  = src_lo_q;
		dst_hi_d  = dst_hi_q;
		dst_lo_d  = dst_lo_q;
		src_ptr_d = src_ptr_q;
		dst_ptr_d = dst_ptr_q;
		blocks_d  = blocks_q;
		hblank_d  = hblank_q;
		active_d  = active_q;
		speed_d   = speed_q;
		armed_d   = armed_q;
		bank_d    = bank_q;
		result    = '0;
		unique case (item.operation)
			cgbvd_pkg::OP_READ: begin
				if (gate) begin
					result.read_data = cgbvd_pkg::READ_NONE;
				end else begin
					unique case (item.reg_address)
						cgbvd_pkg::ADDR_KEY1:  result.read_data = {speed_q, 6'h3F, armed_q};
						cgbvd_pkg::ADDR_SRC_H: result.read_data = src_hi_q;
						cgbvd_pkg::ADDR_SRC_L: result.read_data = src_lo_q;
						cgbvd_pkg::ADDR_DST_H: result.read_data = {3'b0, dst_hi_q};
						cgbvd_pkg::ADDR_DST_L: result.read_data = dst_lo_q;
						cgbvd_pkg::ADDR_CTRL:  result.read_data = {~active_q, blocks_q};
						cgbvd_pkg::ADDR_SVBK:  result.read_data = {5'b0, bank_q};
						default:               result.read_data = cgbvd_pkg::READ_NONE;
					endcase
				end
			end
			cgbvd_pkg::OP_WRITE: begin
				if (!gate) begin
					unique case (item.reg_address)
						cgbvd_pkg::ADDR_KEY1:  armed_d  = item.write_data[0];
						cgbvd_pkg::ADDR_SRC_H: src_hi_d = item.write_data;
						cgbvd_pkg::ADDR_SRC_L: src_lo_d = {item.write_data[7:4], 4'b0};
						cgbvd_pkg::ADDR_DST_H: dst_hi_d = item.write_data[4:0];
						cgbvd_pkg::ADDR_DST_L: dst_lo_d = {item.write_data[7:4], 4'b0};
						cgbvd_pkg::ADDR_CTRL: begin
							if (active_q && hblank_q && !item.write_data[7]) begin
								active_d = 1'b0;
								hblank_d = 1'b0;
							end else begin
								hblank_d  = item.write_data[7];
								blocks_d  = item.write_data[6:0];
								active_d  = 1'b1;
								src_ptr_d = {src_hi_q, src_lo_q};
								dst_ptr_d = {3'b100, dst_hi_q, dst_lo_q};
							end
						end
						cgbvd_pkg::ADDR_SVBK: begin
							bank_d = (item.write_data[2:0] == 3'd0) ? cgbvd_pkg::BANK_RESET
								: item.write_data[2:0];
						end
						default: ;
					endcase
				end
			end
			cgbvd_pkg::OP_TICK: begin
				if (issue) begin
					result.copy_valid   = 1'b1;
					result.copy_source  = src_ptr_q;
					result.copy_dest    = dst_ptr_q;
					result.block_count  = cnt;
					result.stall_cycles = {cnt, 3'b0};
					src_ptr_d = src_ptr_q + step;
					dst_ptr_d = dst_ptr_q + step;
					if (!hblank_q || blocks_q == 7'd0) begin
						blocks_d = cgbvd_pkg::BLOCKS_DONE;
						active_d = 1'b0;
					end else begin
						blocks_d = blocks_q - 7'd1;
					end
				end
			end
			cgbvd_pkg::OP_SPEED: begin
				speed_d = speed_q ^ armed_q;
				armed_d = 1'b0;
			end
			default: ;
		endcase
		result.work_bank    = bank_d;
		result.double_speed = speed_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_hi_q  <= '0;
			src_lo_q  <= '0;
			dst_hi_q  <= '0;
			dst_lo_q  <= '0;
			src_ptr_q <= '0;
			dst_ptr_q <= '0;
			blocks_q  <= '0;
			hblank_q  <= 1'b0;
			active_q  <= 1'b0;
			speed_q   <= 1'b0;
			armed_q   <= 1'b0;
			bank_q    <= cgbvd_pkg::BANK_RESET;
		end else if (fire) begin
			src_hi_q  <= src_hi_d;
			src_lo_q  <= src_lo_d;
			dst_hi_q  <= dst_hi_d;
			dst_lo_q  <= dst_lo_d;
			src_ptr_q <= src_ptr_d;
			dst_ptr_q <= dst_ptr_d;
			blocks_q  <= blocks_d;
			hblank_q  <= hblank_d;
			active_q  <= active_d;
			speed_q   <= speed_d;
			armed_q   <= armed_d;
			bank_q    <= bank_d;
		end
	end

endmodule

// ===== hw/rtl/cgbvd_out_stage.sv =====
// Result register stage of the VRAM DMA register block.
// Depends on cgbvd_pkg for the result word type.
`timescale 1ns / 1ps

module cgbvd_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_valid,
	input  cgbvd_pkg::result_t load_word,
	output logic               advance,
	output logic               out_valid,
	input  logic               out_stall,
	output cgbvd_pkg::result_t word_q
);

	logic valid_q;

	assign advance   = ~valid_q | ~out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load_valid) begin
			word_q <= load_word;
		end
	end

endmodule

// ===== hw/rtl/cgb_vram_dma_and_system_registers.sv =====
// Colour-mode VRAM DMA controller with speed-switch and work-RAM bank registers.
// Input channel (in_valid/in_stall) takes one word: operation, reg_address,
// write_data, in_hblank. Operations are register read, register write, tick
// and speed-switch event. Every accepted word yields exactly one result word
// on the output channel (out_valid/out_stall): read data, an optional copy
// command (source, destination, 16-byte block count, stall cycles) and the
// current bank and speed flag.
// A word accepted is registered in the input stage, processed by the register
// update logic into the result register when free, and shown from then on.
// Throughput: one word per cycle while out_stall is low, set by the single input
// and result register pair around the register update logic.
// A stalled result holds; the input stage still takes a word while it is empty,
// and raises in_stall only when both are full. Reset clears all DMA registers,
// selects bank 1 and normal speed, and sets color_mode. cfg_write loads it from
// cfg_data. The user must write it only while the block is idle; not enforced.
// Depends on cgbvd_pkg, cgbvd_in_stage, cgbvd_core, cgbvd_out_stage.
`timescale 1ns / 1ps

module cgb_vram_dma_and_system_registers (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  reg_address,
	input  logic [7:0]  write_data,
	input  logic        in_hblank,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        copy_valid,
	output logic [15:0] copy_source,
	output logic [15:0] copy_dest,
	output logic [7:0]  block_count,
	output logic [10:0] stall_cycles,
	output logic [2:0]  work_bank,
	output logic        double_speed
);

	logic               color_mode_q;
	logic               advance;
	logic               valid_s1;
	cgbvd_pkg::item_t   item_in;
	cgbvd_pkg::item_t   item_s1;
	cgbvd_pkg::result_t result;
	cgbvd_pkg::result_t word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= 1'b1;
		end else if (cfg_write) begin
			color_mode_q <= cfg_data;
		end
	end

	assign item_in.operation   = cgbvd_pkg::op_t'(operation);
	assign item_in.reg_address = reg_address;
	assign item_in.write_data  = write_data;
	assign item_in.in_hblank   = in_hblank;

	cgbvd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	cgbvd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.color_mode (color_mode_q),
		.fire       (valid_s1 & advance),
		.item       (item_s1),
		.result     (result)
	);

	cgbvd_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_word  (result),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.word_q     (word_q)
	);

	assign read_data    = word_q.read_data;
	assign copy_valid   = word_q.copy_valid;
	assign copy_source  = word_q.copy_source;
	assign copy_dest    = word_q.copy_dest;
	assign block_count  = word_q.block_count;
	assign stall_cycles = word_q.stall_cycles;
	assign work_bank    = word_q.work_bank;
	assign double_speed = word_q.double_speed;

endmodule
